/* sv/rpn_four_level_stack_alu_top_defines.svh */
// assertion macros for the four-level rpn stack alu
// used by the port checker, no other dependencies
`ifndef RPN_FOUR_LEVEL_STACK_ALU_TOP_DEFINES_SVH
`define RPN_FOUR_LEVEL_STACK_ALU_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RPN_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RPN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rpn_pkg.sv */
// shared types and codes for the four-level rpn stack alu
// no dependencies
package rpn_pkg;

    localparam int REQ_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 3'd0,
        REQ_ADD  = 3'd1,
        REQ_SUB  = 3'd2,
        REQ_MUL  = 3'd3,
        REQ_DIV  = 3'd4
    } req_t;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_DIV0 = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic div_op;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             x_zero;
        logic             md_done;
    } sts_t;

endpackage

/* sv/rpn_muldiv.sv */
// iterative shift-add multiplier and restoring divider with saturation
// depends on nothing but its parameters
module rpn_muldiv #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic         is_div,
    input  logic [W-1:0] op_y,
    input  logic [W-1:0] op_x,
    output logic [W-1:0] result,
    output logic         done
);

    localparam int NW = W + F;
    localparam int MW = (2 * W > NW) ? 2 * W : NW;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);
    localparam logic [MW-1:0] POS_LIM = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [MW-1:0] NEG_LIM = POS_LIM + MW'(1);
    localparam logic [W-1:0]  VAL_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  VAL_MIN = {1'b1, {(W - 1){1'b0}}};

    logic            busy_reg, fin_reg, done_reg;
    logic [CW-1:0]   cnt_reg;
    logic            div_reg, neg_reg;
    logic [2*W-1:0]  mcand_reg, acc_reg, acc_next;
    logic [W-1:0]    mplier_reg;
    logic [NW-1:0]   nq_reg, nq_next;
    logic [W-1:0]    rem_reg, rem_next, den_reg;
    logic [W-1:0]    res_reg, res_next;
    logic [W-1:0]    mag_y, mag_x;
    logic [W:0]      rem_sh, rem_diff;
    logic            rem_ge;
    logic [MW-1:0]   mag_full;
    logic            last_step;

    assign mag_y = op_y[W-1] ? -op_y : op_y;
    assign mag_x = op_x[W-1] ? -op_x : op_x;

    // one quotient bit per cycle
    assign rem_sh   = {rem_reg, nq_reg[NW-1]};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign rem_next = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
    assign nq_next  = {nq_reg[NW-2:0], rem_ge};

    // one multiplier bit per cycle
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    assign last_step = cnt_reg == (div_reg ? DIV_LAST : MUL_LAST);

    assign mag_full = div_reg ? MW'(nq_reg) : MW'(acc_reg >> F);

    always_comb begin
        if (neg_reg) begin
            res_next = (mag_full > NEG_LIM) ? VAL_MIN : -mag_full[W-1:0];
        end else begin
            res_next = (mag_full > POS_LIM) ? VAL_MAX : mag_full[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (last_step) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg    <= is_div;
            neg_reg    <= op_y[W-1] ^ op_x[W-1];
            mcand_reg  <= (2 * W)'(mag_y);
            mplier_reg <= mag_x;
            acc_reg    <= '0;
            nq_reg     <= NW'(mag_y) << F;
            rem_reg    <= '0;
            den_reg    <= mag_x;
        end else if (busy_reg) begin
            if (div_reg) begin
                nq_reg  <= nq_next;
                rem_reg <= rem_next;
            end else begin
                acc_reg    <= acc_next;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
        end
        if (fin_reg) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

/* sv/rpn_dp.sv */
// stack registers, add and subtract, result selection and output register
// depends on rpn_pkg
module rpn_dp #(
    parameter int W = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rpn_pkg::cmd_t                 cmd,
    output rpn_pkg::sts_t                 sts,
    input  logic [rpn_pkg::REQ_W-1:0]     in_req,
    input  logic [W-1:0]                  in_value,
    input  logic [W-1:0]                  md_result,
    input  logic                          md_done,
    output logic [W-1:0]                  op_y,
    output logic [W-1:0]                  op_x,
    output logic [W-1:0]                  out_data,
    output logic                          out_status
);

    localparam logic [W-1:0] VAL_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] VAL_MIN = {1'b1, {(W - 1){1'b0}}};

    logic [W-1:0]                x_reg, y_reg, z_reg, t_reg;
    logic [W-1:0]                x_next, y_next, z_next, t_next;
    logic [rpn_pkg::REQ_W-1:0]   req_reg;
    logic [W-1:0]                val_reg;
    logic [W-1:0]                out_data_reg;
    logic                        out_status_reg, status_next;
    logic [W:0]                  sum, dif;
    logic [W-1:0]                add_res, sub_res;
    logic                        x_zero;

    assign x_zero = x_reg == '0;

    assign sum = {y_reg[W-1], y_reg} + {x_reg[W-1], x_reg};
    assign dif = {y_reg[W-1], y_reg} - {x_reg[W-1], x_reg};
    assign add_res = (sum[W] != sum[W-1]) ? (sum[W] ? VAL_MIN : VAL_MAX) : sum[W-1:0];
    assign sub_res = (dif[W] != dif[W-1]) ? (dif[W] ? VAL_MIN : VAL_MAX) : dif[W-1:0];

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        t_next      = t_reg;
        status_next = rpn_pkg::STAT_OK;
        unique case (req_reg)
            rpn_pkg::REQ_PUSH: begin
                x_next = val_reg;
                y_next = x_reg;
                z_next = y_reg;
                t_next = z_reg;
            end
            rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL: begin
                x_next = (req_reg == rpn_pkg::REQ_ADD) ? add_res :
                         (req_reg == rpn_pkg::REQ_SUB) ? sub_res : md_result;
                y_next = z_reg;
                z_next = t_reg;
                t_next = '0;
            end
            rpn_pkg::REQ_DIV: begin
                if (x_zero) begin
                    status_next = rpn_pkg::STAT_DIV0;
                end else begin
                    x_next = md_result;
                    y_next = z_reg;
                    z_next = t_reg;
                    t_next = '0;
                end
            end
            default: begin
                // undefined request codes leave the stack alone
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            t_reg <= '0;
        end else if (cmd.commit) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            t_reg <= t_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= in_req;
            val_reg <= in_value;
        end
        if (cmd.commit) begin
            out_data_reg   <= x_next;
            out_status_reg <= status_next;
        end
    end

    assign sts.req     = req_reg;
    assign sts.x_zero  = x_zero;
    assign sts.md_done = md_done;

    assign op_y       = y_reg;
    assign op_x       = x_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

/* sv/rpn_ctrl.sv */
// request sequencer and output word handshake
// depends on rpn_pkg
module rpn_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rpn_pkg::sts_t sts,
    output rpn_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   needs_md;
    logic   out_free;

    assign needs_md = (sts.req == rpn_pkg::REQ_MUL) ||
                      ((sts.req == rpn_pkg::REQ_DIV) && !sts.x_zero);
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready     = state_reg == ST_IDLE;
    assign m_valid     = out_valid_reg;
    assign cmd.capture = (state_reg == ST_IDLE) && s_valid;
    assign cmd.start   = (state_reg == ST_EXEC) && needs_md;
    assign cmd.div_op  = sts.req == rpn_pkg::REQ_DIV;
    assign cmd.commit  = (state_reg == ST_DONE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= needs_md ? ST_WAIT : ST_DONE;
                end
                ST_WAIT: begin
                    if (sts.md_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* sv/rpn_four_level_stack_alu_top.sv */
// Four-level RPN stack calculator (X, Y, Z, T) in signed fixed point.
// Input words: s_tuser carries the request (push, add, subtract, multiply,
// divide), s_tdata the value to push. Output words: m_tdata carries X after
// the request, m_tuser the status (set on a divide by zero, stack unchanged).
// One request is worked on at a time; one result word per request.
// After an input word is accepted, the request passes through an execute
// state; multiply and nonzero divide then wait for the shared multiply/divide
// unit, which handles one operand bit per cycle. The result is then committed
// to the output register, which raises m_tvalid, and only after that is the
// next input word taken.
// A finished word waits in the output register while the next request is
// accepted; if m_tready stays low, the following result holds the stack
// update until the register is free, and m_tdata/m_tuser stay stable.
// Reset (aresetn low at a clock edge) clears X, Y, Z, T to zero and drops
// m_tvalid.
// depends on rpn_pkg, rpn_ctrl, rpn_dp, rpn_muldiv
module rpn_four_level_stack_alu_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
    input  logic [rpn_pkg::REQ_W-1:0]            s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // top_value
    output logic [0:0]                           m_tuser   // status
);

    localparam int TW = ((DATA_WIDTH + 7) / 8) * 8;

    rpn_pkg::cmd_t         cmd;
    rpn_pkg::sts_t         sts;
    logic [DATA_WIDTH-1:0] op_y, op_x, md_result, out_data;
    logic                  md_done, out_status;

    rpn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rpn_muldiv #(
        .W (DATA_WIDTH),
        .F (FRAC_BITS)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .is_div  (cmd.div_op),
        .op_y    (op_y),
        .op_x    (op_x),
        .result  (md_result),
        .done    (md_done)
    );

    rpn_dp #(
        .W (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_req     (s_tuser),
        .in_value   (s_tdata[DATA_WIDTH-1:0]),
        .md_result  (md_result),
        .md_done    (md_done),
        .op_y       (op_y),
        .op_x       (op_x),
        .out_data   (out_data),
        .out_status (out_status)
    );

    assign m_tdata    = TW'(out_data);
    assign m_tuser[0] = out_status;

endmodule

/* sv/rpn_four_level_stack_alu_top_chk.sv */
// port-level checker for the four-level rpn stack alu, bound to the top level
// depends on rpn_four_level_stack_alu_top_defines.svh
`include "rpn_four_level_stack_alu_top_defines.svh"

module rpn_four_level_stack_alu_top_chk #(
    parameter int DATA_WIDTH = 32
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    input logic [0:0]                           m_tuser
);

    // stalled output word holds
    `RPN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

    // one request in flight: no accept right after an accept
    `RPN_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a request is in flight")

    // divide by zero leaves X at zero
    `RPN_ASSERT_SAME(a_div0_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0, "divide by zero status with nonzero X")

    // a result word only appears while no input is being taken
    `RPN_ASSERT_SAME(a_result_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result word appeared without a request in flight")

endmodule

bind rpn_four_level_stack_alu_top rpn_four_level_stack_alu_top_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_chk (.*);
